@@ sv/iog_pkg.sv @@
// package for the image to occupancy grid block
// register indexes, reset values, size limits and the dimension clamp; no dependencies
package iog_pkg;

  localparam int unsigned MaxCellColumns = 64;
  localparam int unsigned MaxCellRows    = 64;

  localparam int unsigned DimW  = 13;
  localparam int unsigned CntW  = 12;
  localparam int unsigned RowW  = 6;
  localparam int unsigned MaskW = 64;
  localparam int unsigned PixW  = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [PixW-1:0] FreePixel = 8'd255;
  localparam logic [DimW-1:0] DimLimit  = 13'd4096;

  localparam logic [DimW-1:0] ImageWidthRst  = 13'd640;
  localparam logic [DimW-1:0] ImageHeightRst = 13'd480;
  localparam logic [DimW-1:0] CellWidthRst   = 13'd32;
  localparam logic [DimW-1:0] CellHeightRst  = 13'd32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_CELL_WIDTH   = 2'd2,
    REG_CELL_HEIGHT  = 2'd3
  } cfg_reg_t;

  // zero acts as one, anything above the limit acts as the limit
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > DimLimit) begin
      r = DimLimit;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ sv/image_to_occupancy_grid_unit.sv @@
// path: an accepted pixel goes into the input register, and a band result is loaded into the
// result register when its last pixel is processed; the outputs are driven from that register
// throughput: one pixel per cycle; the input stalls only when a band-ending pixel meets a
// result that is still held by a stalled output
// reset: rst_n synchronous active low, clears counters, mask, valids and loads register defaults
// top level of the image to occupancy grid block; uses iog_pkg
module image_to_occupancy_grid_unit
  import iog_pkg::*;
#(
  parameter int unsigned MAX_CELL_COLUMNS = MaxCellColumns
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [DimW-1:0]     cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [PixW-1:0]     in_pixel,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [RowW-1:0]     out_band_index,
  output logic [MaskW-1:0]    out_occupied_mask,
  output logic                out_frame_end
);

  localparam int unsigned CcW = $clog2(MAX_CELL_COLUMNS + 1);
  localparam logic [CcW-1:0] CcMax = CcW'(MAX_CELL_COLUMNS);
  localparam logic [RowW:0] RowMax = (RowW+1)'(MaxCellRows);

  // configuration
  logic [DimW-1:0] image_width_r, image_height_r, cell_width_r, cell_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= ImageWidthRst;
      image_height_r <= ImageHeightRst;
      cell_width_r   <= CellWidthRst;
      cell_height_r  <= CellHeightRst;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height_r <= cfg_data;
        REG_CELL_WIDTH:   cell_width_r   <= cfg_data;
        REG_CELL_HEIGHT:  cell_height_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [DimW-1:0] iw, ih, cw, ch;
  assign iw = clamp_dim(image_width_r);
  assign ih = clamp_dim(image_height_r);
  assign cw = clamp_dim(cell_width_r);
  assign ch = clamp_dim(cell_height_r);

  // input register
  logic            a_valid_r;
  logic [PixW-1:0] a_pixel_r;

  // scan state
  logic [CntW-1:0]             pixel_column_r, pixel_column_nxt;
  logic [CntW-1:0]             pixel_row_r, pixel_row_nxt;
  logic [CntW-1:0]             offset_x_r, offset_x_nxt;
  logic [CntW-1:0]             offset_y_r, offset_y_nxt;
  logic [CcW-1:0]              cell_column_r, cell_column_nxt;
  logic [RowW-1:0]             cell_row_r, cell_row_nxt;
  logic [MAX_CELL_COLUMNS-1:0] band_mask_r, band_mask_nxt, mask_set;

  logic [DimW-1:0] pc_inc, pr_inc, ox_inc, oy_inc;
  logic            row_end, frame_done, band_done, produces, out_free, proc_go;

  assign pc_inc = {1'b0, pixel_column_r} + DimW'(1);
  assign pr_inc = {1'b0, pixel_row_r} + DimW'(1);
  assign ox_inc = {1'b0, offset_x_r} + DimW'(1);
  assign oy_inc = {1'b0, offset_y_r} + DimW'(1);

  assign row_end    = pc_inc >= iw;
  assign frame_done = pr_inc >= ih;
  assign band_done  = frame_done || (oy_inc >= ch);
  assign produces   = row_end && band_done;

  assign out_free = !out_valid || !out_stall;
  assign proc_go  = a_valid_r && (!produces || out_free);
  assign in_stall = a_valid_r && !proc_go;

  always_comb begin
    mask_set = band_mask_r;
    if (a_pixel_r != FreePixel && cell_column_r < CcMax) begin
      mask_set = band_mask_r | (MAX_CELL_COLUMNS'(1) << cell_column_r);
    end

    pixel_column_nxt = pixel_column_r;
    pixel_row_nxt    = pixel_row_r;
    offset_x_nxt     = offset_x_r;
    offset_y_nxt     = offset_y_r;
    cell_column_nxt  = cell_column_r;
    cell_row_nxt     = cell_row_r;
    band_mask_nxt    = mask_set;

    if (ox_inc >= cw) begin
      offset_x_nxt = '0;
      if (cell_column_r < CcMax) begin
        cell_column_nxt = cell_column_r + CcW'(1);
      end
    end else begin
      offset_x_nxt = ox_inc[CntW-1:0];
    end

    if (!row_end) begin
      pixel_column_nxt = pc_inc[CntW-1:0];
    end else begin
      pixel_column_nxt = '0;
      offset_x_nxt     = '0;
      cell_column_nxt  = '0;
      if (!band_done) begin
        pixel_row_nxt = pr_inc[CntW-1:0];
        offset_y_nxt  = oy_inc[CntW-1:0];
      end else begin
        band_mask_nxt = '0;
        offset_y_nxt  = '0;
        if (frame_done) begin
          pixel_row_nxt = '0;
          cell_row_nxt  = '0;
        end else begin
          pixel_row_nxt = pr_inc[CntW-1:0];
          // tall images keep reporting the last band index
          if ({1'b0, cell_row_r} + (RowW+1)'(1) < RowMax) begin
            cell_row_nxt = cell_row_r + RowW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r      <= 1'b0;
      pixel_column_r <= '0;
      pixel_row_r    <= '0;
      offset_x_r     <= '0;
      offset_y_r     <= '0;
      cell_column_r  <= '0;
      cell_row_r     <= '0;
      band_mask_r    <= '0;
    end else begin
      if (!in_stall) begin
        a_valid_r <= in_valid;
      end
      if (proc_go) begin
        pixel_column_r <= pixel_column_nxt;
        pixel_row_r    <= pixel_row_nxt;
        offset_x_r     <= offset_x_nxt;
        offset_y_r     <= offset_y_nxt;
        cell_column_r  <= cell_column_nxt;
        cell_row_r     <= cell_row_nxt;
        band_mask_r    <= band_mask_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      a_pixel_r <= in_pixel;
    end
  end

  // result register
  logic             out_valid_r;
  logic [RowW-1:0]  out_band_r;
  logic [MaskW-1:0] out_mask_r;
  logic             out_frame_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_go && produces) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && produces) begin
      out_band_r  <= cell_row_r;
      out_mask_r  <= MaskW'(mask_set);
      out_frame_r <= frame_done;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_band_index    = out_band_r;
  assign out_occupied_mask = out_mask_r;
  assign out_frame_end     = out_frame_r;

endmodule

@@ sv/iog_checker.sv @@
// port-level checks for image_to_occupancy_grid_unit and the bind that attaches them
// uses iog_pkg for port widths
module iog_checker
  import iog_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [RowW-1:0]    out_band_index,
  input logic [MaskW-1:0]   out_occupied_mask,
  input logic               out_frame_end
);

  // reset empties both the pipeline and the result register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("valid or stall set after reset");

  // the input only backs up behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_band_index)
      && $stable(out_occupied_mask) && $stable(out_frame_end))
    else $error("stalled result changed");

endmodule

bind image_to_occupancy_grid_unit iog_checker u_iog_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_band_index    (out_band_index),
  .out_occupied_mask (out_occupied_mask),
  .out_frame_end     (out_frame_end)
);

@@ tb/sv/tb_top.sv @@
// self-checking testbench for image_to_occupancy_grid_unit: pixel stream in, band masks out
// a built-in grid predictor checks every band result; needs iog_pkg and the block's rtl
`timescale 1ns / 100ps

module tb_top;
  import iog_pkg::*;

  typedef struct packed {
    logic [RowW-1:0]  band;
    logic [MaskW-1:0] mask;
    logic             frame_end;
  } band_t;

  typedef struct packed {
    logic                is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [DimW-1:0]     value;
    logic                typed;
    band_t               want;
  } stim_row_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [DimW-1:0]     cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [PixW-1:0]     in_pixel = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [RowW-1:0]     out_band_index;
  logic [MaskW-1:0]    out_occupied_mask;
  logic                out_frame_end;

  image_to_occupancy_grid_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pixel          (in_pixel),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_band_index    (out_band_index),
    .out_occupied_mask (out_occupied_mask),
    .out_frame_end     (out_frame_end)
  );

  // shadow registers and grid position of the predictor
  logic [DimW-1:0]  img_w_q  = ImageWidthRst;
  logic [DimW-1:0]  img_h_q  = ImageHeightRst;
  logic [DimW-1:0]  cell_w_q = CellWidthRst;
  logic [DimW-1:0]  cell_h_q = CellHeightRst;
  logic [CntW-1:0]  pix_col_q  = '0;
  logic [CntW-1:0]  pix_row_q  = '0;
  logic [CntW-1:0]  offx_q     = '0;
  logic [CntW-1:0]  offy_q     = '0;
  logic [6:0]       cell_col_q = '0;
  logic [RowW-1:0]  cell_row_q = '0;
  logic [MaskW-1:0] mask_q     = '0;

  band_t     band_queue [$];
  stim_row_t directed [$];
  bit        quiet = 1'b0;
  int        fail_count = 0;
  int        stall_left = 0;
  band_t     want_q;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_top failed");
    $finish;
  end

  function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] v);
    if (v == '0) return DimW'(1);
    if (v > DimLimit) return DimLimit;
    return v;
  endfunction

  // advance the grid by one pixel; returns 1 when a band closes
  function automatic bit grid_step(input logic [PixW-1:0] pix, output band_t res);
    int iw, ih, cw, ch;
    bit frame_done, band_done;
    iw = int'(eff_dim(img_w_q));
    ih = int'(eff_dim(img_h_q));
    cw = int'(eff_dim(cell_w_q));
    ch = int'(eff_dim(cell_h_q));
    res = '0;
    if (pix != FreePixel && cell_col_q < MaxCellColumns) mask_q[cell_col_q] = 1'b1;
    if (int'(offx_q) + 1 >= cw) begin
      offx_q = '0;
      if (cell_col_q < MaxCellColumns) cell_col_q++;
    end else begin
      offx_q++;
    end
    if (int'(pix_col_q) + 1 < iw) begin
      pix_col_q++;
      return 1'b0;
    end
    pix_col_q  = '0;
    offx_q     = '0;
    cell_col_q = '0;
    frame_done = (int'(pix_row_q) + 1 >= ih);
    band_done  = frame_done || (int'(offy_q) + 1 >= ch);
    if (!band_done) begin
      pix_row_q++;
      offy_q++;
      return 1'b0;
    end
    res.band      = cell_row_q;
    res.mask      = mask_q;
    res.frame_end = frame_done;
    mask_q = '0;
    offy_q = '0;
    if (frame_done) begin
      pix_row_q  = '0;
      cell_row_q = '0;
    end else begin
      pix_row_q++;
      if (int'(cell_row_q) + 1 < int'(MaxCellRows)) cell_row_q++;
    end
    return 1'b1;
  endfunction

  function automatic logic [DimW-1:0] pick_cell(input int hi);
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return DimLimit;
      2:       return 13'h1FFF;
      default: return DimW'($urandom_range(1, hi));
    endcase
  endfunction

  function void add_cfg(input cfg_reg_t idx, input logic [DimW-1:0] v);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.value  = v;
    directed.push_back(r);
  endfunction

  function void add_pix(input logic [PixW-1:0] p);
    stim_row_t r;
    r = '0;
    r.value = DimW'(p);
    directed.push_back(r);
  endfunction

  function void add_band_pix(input logic [PixW-1:0] p, input logic [RowW-1:0] band,
                             input logic [MaskW-1:0] mask, input logic fe);
    stim_row_t r;
    r = '0;
    r.value = DimW'(p);
    r.typed = 1'b1;
    r.want  = '{band: band, mask: mask, frame_end: fe};
    directed.push_back(r);
  endfunction

  // register write at the next edge; the enable is lowered by the next pixel request
  task automatic write_reg(input cfg_reg_t idx, input logic [DimW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:  img_w_q  = v;
      REG_IMAGE_HEIGHT: img_h_q  = v;
      REG_CELL_WIDTH:   cell_w_q = v;
      REG_CELL_HEIGHT:  cell_h_q = v;
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [DimW-1:0] w, input logic [DimW-1:0] h,
                             input logic [DimW-1:0] cw, input logic [DimW-1:0] ch);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_CELL_WIDTH, cw);
    write_reg(REG_CELL_HEIGHT, ch);
  endtask

  task automatic send_pixel(input logic [PixW-1:0] pix, input logic typed, input band_t want);
    int    gap;
    band_t res;
    gap = quiet ? 0 : $urandom_range(0, 13);
    cfg_we <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= pix;
    // hold the request until the block takes it
    do @(posedge clk); while (in_stall);
    if (grid_step(pix, res)) band_queue.push_back(typed ? want : res);
  endtask

  // wait for every band to come out, then for the pipeline to empty
  task automatic settle();
    in_valid <= 1'b0;
    while (band_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (band_queue.size() == 0) begin
        $display("%0t: unexpected band result band=%0d mask=%h frame_end=%0d", $time,
                 out_band_index, out_occupied_mask, out_frame_end);
        fail_count++;
      end else begin
        want_q = band_queue.pop_front();
        if (out_band_index !== want_q.band) begin
          $display("%0t: band_index expected %0d actual %0d", $time, want_q.band,
                   out_band_index);
          fail_count++;
        end
        if (out_occupied_mask !== want_q.mask) begin
          $display("%0t: occupied_mask expected %h actual %h", $time, want_q.mask,
                   out_occupied_mask);
          fail_count++;
        end
        if (out_frame_end !== want_q.frame_end) begin
          $display("%0t: frame_end expected %0d actual %0d", $time, want_q.frame_end,
                   out_frame_end);
          fail_count++;
        end
      end
      stall_left = quiet ? 0 : $urandom_range(0, 13);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin : stimulus
    bit               prev_pix;
    int               random_items;
    int               kind;
    int               density;
    int               frame;
    int               count;
    logic [DimW-1:0]  w, h, cw, ch;
    logic [PixW-1:0]  pix;

    // default cell size covers both pixels of a two pixel frame
    add_cfg(REG_IMAGE_WIDTH, 13'd2);
    add_cfg(REG_IMAGE_HEIGHT, 13'd1);
    add_pix(8'd255);
    add_band_pix(8'd0, 6'd0, 64'h1, 1'b1);
    add_pix(8'd255);
    add_band_pix(8'd255, 6'd0, 64'h0, 1'b1);
    // one pixel cells, 3x2 image
    add_cfg(REG_CELL_WIDTH, 13'd1);
    add_cfg(REG_CELL_HEIGHT, 13'd1);
    add_cfg(REG_IMAGE_WIDTH, 13'd3);
    add_cfg(REG_IMAGE_HEIGHT, 13'd2);
    add_pix(8'd0);
    add_pix(8'd255);
    add_band_pix(8'd1, 6'd0, 64'h5, 1'b0);
    add_pix(8'd255);
    add_pix(8'd254);
    add_band_pix(8'd255, 6'd1, 64'h2, 1'b1);
    // zero cell width acts as one
    add_cfg(REG_CELL_WIDTH, 13'd0);
    add_pix(8'd255);
    add_pix(8'd255);
    add_band_pix(8'd128, 6'd0, 64'h4, 1'b0);
    add_pix(8'd127);
    add_pix(8'd255);
    add_band_pix(8'd255, 6'd1, 64'h1, 1'b1);
    // out of range values clamp: width 1, height 4096, cell 4096 x 1
    add_cfg(REG_IMAGE_WIDTH, 13'd0);
    add_cfg(REG_IMAGE_HEIGHT, 13'h1FFF);
    add_cfg(REG_CELL_WIDTH, 13'h1FFF);
    add_cfg(REG_CELL_HEIGHT, 13'd0);
    add_band_pix(8'd255, 6'd0, 64'h0, 1'b0);
    add_band_pix(8'd0, 6'd1, 64'h1, 1'b0);
    add_band_pix(8'd85, 6'd2, 64'h1, 1'b0);
    add_band_pix(8'd170, 6'd3, 64'h1, 1'b0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    prev_pix = 1'b0;
    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        if (prev_pix) settle();
        write_reg(cfg_reg_t'(directed[i].idx), directed[i].value);
        prev_pix = 1'b0;
      end else begin
        send_pixel(directed[i].value[PixW-1:0], directed[i].typed, directed[i].want);
        prev_pix = 1'b1;
      end
    end

    // full mask width: one row of 256 pixels in 64 four pixel cells
    settle();
    quiet = 1'b1;
    load_config(13'd256, 13'd1, 13'd4, DimLimit);
    repeat (256) begin
      pix = ($urandom_range(0, 999) < 60) ? PixW'($urandom_range(0, 254)) : FreePixel;
      send_pixel(pix, 1'b0, '0);
    end

    random_items = 0;
    while (random_items < 800) begin
      settle();
      quiet   = ($urandom_range(0, 3) == 0);
      density = $urandom_range(0, 30);
      kind    = $urandom_range(0, 19);
      if (kind == 0) begin
        // may have more cell columns than the mask holds
        w  = DimW'($urandom_range(65, 140));
        h  = DimW'($urandom_range(1, 2));
        cw = DimW'($urandom_range(1, 2));
        ch = DimW'($urandom_range(1, 2));
      end else if (kind == 1) begin
        // tall frame, one band per pixel, band index runs into saturation
        w  = DimW'($urandom_range(0, 1));
        h  = $urandom_range(0, 1) ? DimLimit : 13'h1FFF;
        cw = pick_cell(5);
        ch = DimW'($urandom_range(0, 1));
      end else begin
        w  = DimW'($urandom_range(1, 12));
        h  = DimW'($urandom_range(1, 10));
        cw = pick_cell(5);
        ch = pick_cell(4);
      end
      load_config(w, h, cw, ch);
      frame = int'(eff_dim(w)) * int'(eff_dim(h));
      if (kind == 1) count = $urandom_range(70, 90);
      else if ($urandom_range(0, 3) == 0) count = $urandom_range(1, frame + 5);
      else count = frame;
      repeat (count) begin
        pix = ($urandom_range(0, 99) < density) ? PixW'($urandom_range(0, 255)) : FreePixel;
        send_pixel(pix, 1'b0, '0);
        random_items++;
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
